[sv/shortest_path_all_predecessors_assert.svh]
// Assertion macros for the shortest path block.
`ifndef SHORTEST_PATH_ALL_PREDECESSORS_ASSERT_SVH
`define SHORTEST_PATH_ALL_PREDECESSORS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPAP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPAP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/spap_pkg.sv]
`default_nettype none
package spap_pkg;
	localparam int NV = 32;
	localparam int VW = 5;
	localparam int WB = 32;
	localparam int DW = 40;
	localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};
	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_INIT  = 8'b00000010,
		ST_SCAN  = 8'b00000100,
		ST_PICK  = 8'b00001000,
		ST_RELAX = 8'b00010000,
		ST_EMIT  = 8'b00100000,
		ST_LOAD  = 8'b01000000,
		ST_CLEAR = 8'b10000000
	} state_t;

	typedef struct packed {
		logic clear;
		logic init;
		logic scan;
		logic pick;
		logic relax;
		logic load;
		logic emit;
		logic [VW-1:0] idx;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic clr_done;
	} sts_t;
endpackage
`default_nettype wire

[sv/spap_datapath.sv]
`default_nettype none
module spap_datapath (
	input  wire logic                      clk,
	input  wire spap_pkg::cmd_t            cmd,
	output spap_pkg::sts_t                 sts,
	input  wire logic [spap_pkg::VW-1:0]   src,
	input  wire logic [spap_pkg::VW-1:0]   wr_row,
	input  wire logic [spap_pkg::VW-1:0]   wr_col,
	input  wire logic [spap_pkg::WB-1:0]   wr_weight,
	input  wire logic [spap_pkg::VW:0]     count,
	input  wire logic                      arst_n,
	output logic [spap_pkg::DW-1:0]        o_dist,
	output logic                           o_reach,
	output logic [spap_pkg::NV-1:0]        o_pred
);
	import spap_pkg::*;

	logic [WB-1:0] mem [NV*NV];
	logic [WB-1:0] rd_q;
	logic          load_s1;
	logic [2*VW-1:0] clr_q;
	logic [DW-1:0] dist_q [NV];
	logic [NV-1:0] pred_q [NV];
	logic [NV-1:0] settled_q;
	logic [NV-1:0] reached_q;
	logic [VW-1:0] pick_q;
	logic          found_q;
	logic [DW-1:0] min_q;
	logic [VW-1:0] rlx_s1;
	logic          rlx_v_s1;
	logic [VW-1:0] rd_addr_v;
	logic [DW:0]   sum;
	logic [DW-1:0] cand;
	logic          vin;
	logic          take;

	// Edge matrix: the load writes the second direction in the cycle after the first.
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= '0;
		end else if (cmd.load) begin
			mem[{wr_row, wr_col}] <= wr_weight;
		end else if (load_s1) begin
			mem[{wr_col, wr_row}] <= wr_weight;
		end
		rd_q <= mem[{pick_q, cmd.idx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1  <= 1'b0;
			rlx_v_s1 <= 1'b0;
			clr_q    <= '0;
		end else begin
			load_s1  <= cmd.load;
			rlx_v_s1 <= cmd.relax;
			if (cmd.clear) begin
				clr_q <= clr_q + (2*VW)'(1);
			end
		end
	end

	assign rd_addr_v = cmd.idx;
	assign vin = ({1'b0, rlx_s1} < count);
	assign sum = {1'b0, dist_q[pick_q]} + {{(DW+1-WB){1'b0}}, rd_q};
	assign cand = sum[DW] ? DIST_MAX : sum[DW-1:0];
	assign take = !settled_q[cmd.idx] && reached_q[cmd.idx] &&
		((cmd.first || !found_q) || dist_q[cmd.idx] < min_q);

	always_ff @(posedge clk) begin
		rlx_s1 <= rd_addr_v;
		if (cmd.init) begin
			settled_q[cmd.idx] <= 1'b0;
			reached_q[cmd.idx] <= (cmd.idx == src);
			dist_q[cmd.idx]    <= '0;
			pred_q[cmd.idx]    <= '0;
		end
		if (cmd.scan) begin
			found_q <= take || (!cmd.first && found_q);
			if (take) begin
				min_q   <= dist_q[cmd.idx];
				pick_q  <= cmd.idx;
			end
		end
		if (cmd.pick) begin
			settled_q[pick_q] <= 1'b1;
		end
		if (rlx_v_s1 && vin && rd_q != '0 && !settled_q[rlx_s1]) begin
			if (!reached_q[rlx_s1] || cand < dist_q[rlx_s1]) begin
				reached_q[rlx_s1] <= 1'b1;
				dist_q[rlx_s1]    <= cand;
				pred_q[rlx_s1]    <= NV'(1) << pick_q;
			end else if (cand == dist_q[rlx_s1]) begin
				pred_q[rlx_s1] <= pred_q[rlx_s1] | (NV'(1) << pick_q);
			end
		end
	end

	assign sts.found    = found_q;
	assign sts.clr_done = (clr_q == '1);
	assign o_reach = reached_q[cmd.idx];
	assign o_dist  = reached_q[cmd.idx] ? dist_q[cmd.idx] : DIST_MAX;
	assign o_pred  = reached_q[cmd.idx] ? pred_q[cmd.idx] : '0;
endmodule
`default_nettype wire

[sv/spap_ctrl.sv]
`default_nettype none
module spap_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_go,
	input  wire logic                    in_kind,
	input  wire logic [spap_pkg::VW:0]   count,
	input  wire spap_pkg::sts_t          sts,
	input  wire logic                    out_taken,
	output spap_pkg::cmd_t               cmd,
	output spap_pkg::state_t             state,
	output logic                         emit_last
);
	import spap_pkg::*;

	state_t        state_q;
	logic [VW:0]   idx_q;
	logic [VW:0]   pass_q;
	logic [VW:0]   lastv;

	assign lastv = count - (VW+1)'(1);
	assign state = state_q;
	assign emit_last = (idx_q == lastv);

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q[VW-1:0];
		cmd.first = (idx_q == '0);
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_LOAD:  cmd.load = 1'b1;
			ST_INIT:  cmd.init = 1'b1;
			ST_SCAN:  cmd.scan = 1'b1;
			ST_PICK:  cmd.pick = sts.found;
			ST_RELAX: cmd.relax = 1'b1;
			ST_EMIT:  cmd.emit = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q  <= '0;
					pass_q <= '0;
					if (in_go) begin
						state_q <= in_kind == KIND_LOAD ? ST_LOAD : ST_INIT;
					end
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_INIT: begin
					if (idx_q == (VW+1)'(NV-1)) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q <= idx_q + (VW+1)'(1);
					end
				end
				ST_SCAN: begin
					if (idx_q == lastv) begin
						idx_q   <= '0;
						state_q <= ST_PICK;
					end else begin
						idx_q <= idx_q + (VW+1)'(1);
					end
				end
				ST_PICK: begin
					state_q <= sts.found ? ST_RELAX : ST_EMIT;
				end
				ST_RELAX: begin
					if (idx_q == (VW+1)'(NV-1)) begin
						idx_q  <= '0;
						pass_q <= pass_q + (VW+1)'(1);
						state_q <= (pass_q == lastv) ? ST_EMIT : ST_SCAN;
					end else begin
						idx_q <= idx_q + (VW+1)'(1);
					end
				end
				ST_EMIT: begin
					if (out_taken) begin
						idx_q <= idx_q + (VW+1)'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/shortest_path_all_predecessors.sv]
// Shortest path search with all tied predecessors kept.
// The in channel (in_valid/in_ready) carries one transaction per item.
// kind 0 writes an edge weight both ways into a 32x32 matrix.
// kind 1 runs a search from source_vertex over the first vertex_count vertices.
// A run first clears the per-vertex state of all 32 vertices, then for each
// of up to N passes runs a scan over the N vertices, a pick step and a relax
// pass over all 32 columns of the picked row through the single matrix read
// port.
// It then emits one out transaction per vertex in index order, last set
// on the final one. A run with the source outside the count emits nothing.
// The out channel holds its payload while out_ready is low; the block waits.
// The cfg channel writes vertex_count; it is taken while the block is idle.
// After reset the block clears all 1024 entries of the edge matrix, with
// in_ready and cfg_ready low, so every edge starts absent.
// in_ready is high only in the idle state.
`default_nettype none
`include "shortest_path_all_predecessors_assert.svh"
module shortest_path_all_predecessors (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [0:0]  kind,
	input  wire logic [4:0]  row,
	input  wire logic [4:0]  col,
	input  wire logic [31:0] weight,
	input  wire logic [4:0]  source_vertex,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       vertex,
	output logic [39:0]      distance,
	output logic             reachable,
	output logic [31:0]      predecessors,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data
);
	import spap_pkg::*;

	logic [5:0]    vc_q;
	logic [VW:0]   count;
	logic [VW-1:0] src_q;
	logic [VW-1:0] row_q;
	logic [VW-1:0] col_q;
	logic [WB-1:0] w_q;
	logic          go;
	logic          ok;
	cmd_t          cmd;
	sts_t          sts;
	state_t        state;
	logic          emit_last;
	logic [DW-1:0] dist_c;
	logic          reach_c;
	logic [NV-1:0] pred_c;

	assign count = (vc_q == '0) ? 6'd1 : (vc_q > 6'd32 ? 6'd32 : vc_q);
	assign in_ready = (state == ST_IDLE);
	assign cfg_ready = (state == ST_IDLE);
	assign ok = kind == KIND_LOAD || ({1'b0, source_vertex} < count);
	assign go = in_valid && in_ready && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			src_q <= source_vertex;
			row_q <= row;
			col_q <= col;
			w_q   <= weight;
		end
	end

	spap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(go), .in_kind(kind[0]), .count(count),
		.sts(sts), .out_taken(out_valid && out_ready), .cmd(cmd), .state(state),
		.emit_last(emit_last)
	);

	spap_datapath u_dp (
		.clk(clk), .cmd(cmd), .sts(sts), .src(src_q), .wr_row(row_q),
		.wr_col(col_q), .wr_weight(w_q), .count(count), .arst_n(arst_n),
		.o_dist(dist_c), .o_reach(reach_c), .o_pred(pred_c)
	);

	assign out_valid    = (state == ST_EMIT);
	assign vertex       = cmd.idx;
	assign distance     = dist_c;
	assign reachable    = reach_c;
	assign predecessors = pred_c;
	assign last         = emit_last;

	`SPAP_ASSERT_IMP(a_out_idle, clk, arst_n, out_valid, !in_ready)
	`SPAP_ASSERT_IMP(a_src_dist, clk, arst_n, out_valid && vertex == src_q,
		distance == '0 && reachable)
	`SPAP_ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && last,
		in_ready)
endmodule
`default_nettype wire
